// ===== sv/dspg_pkg.sv =====
// Package with the shared types and constants of the DDA step-pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package dspg_pkg;

  localparam int FIFO_DEPTH = 10;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam int STEP_W = 16;
  localparam int ACC_W  = 17;
  localparam int RATE_W = 4;
  localparam int TICK_W = 7;

  localparam logic [TICK_W-1:0] GATE_TOP  = TICK_W'(100);
  localparam logic [TICK_W-1:0] GATE_HALF = TICK_W'(50);
  localparam logic [STEP_W-1:0] RATE_MAX  = STEP_W'(10);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_PUSH   = 2'd1,
    MODE_PRESET = 2'd2,
    MODE_LOAD   = 2'd3
  } mode_t;

  // Commands from the core logic to the command FIFO.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [STEP_W-1:0] data;
  } fifo_ctrl_t;

  // One result item.
  typedef struct packed {
    logic pulse;
    logic clk1;
    logic flag;
    logic wrap;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/dspg_cmd_fifo.sv =====
// Command FIFO of step counts: shift register with saturating fill count.
`timescale 1ns / 1ps
`default_nettype none
module dspg_cmd_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dspg_pkg::fifo_ctrl_t       ctrl,
  output logic [dspg_pkg::STEP_W-1:0]     head
);
  import dspg_pkg::*;

  logic [STEP_W-1:0] fifo_r [FIFO_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] fill_inc;
  logic [IDX_W-1:0]  wr_idx;

  // A push into a full FIFO overwrites the last entry.
  always_comb begin
    fill_inc = (fill_r < FILL_W'(FIFO_DEPTH)) ? fill_r + FILL_W'(1) : fill_r;
    wr_idx   = IDX_W'(fill_inc - FILL_W'(1));
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (ctrl.push) begin
      fill_nxt = fill_inc;
    end else if (ctrl.pop && (fill_r != '0)) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      fill_r <= '0;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        fifo_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      if (ctrl.push) begin
        fifo_r[wr_idx] <= ctrl.data;
      end else if (ctrl.pop) begin
        for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
          fifo_r[i] <= fifo_r[i+1];
        end
        fifo_r[FIFO_DEPTH-1] <= '0;
      end
    end
  end

  // Entries at and above the fill count always hold zero, so an empty pop reads zero.
  assign head = fifo_r[0];

endmodule
`default_nettype wire

// ===== sv/dspg_core_logic.sv =====
// Gate counter, frame counter and DDA accumulator with their per-item update.
`timescale 1ns / 1ps
`default_nettype none
module dspg_core_logic (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic [1:0]                 mode,
  input  wire logic                       enable,
  input  wire logic                       preset_held,
  input  wire logic [dspg_pkg::STEP_W-1:0] step_count,
  input  wire logic [dspg_pkg::STEP_W-1:0] period_n,
  input  wire logic [dspg_pkg::STEP_W-1:0] fifo_head,
  output dspg_pkg::fifo_ctrl_t            fifo_ctrl,
  output dspg_pkg::result_t               result
);
  import dspg_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              clk1_r, clk1_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ACC_W-1:0]  frame_r, frame_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0] period_r, period_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic              gate_on;
  logic              wrap;
  logic              half_gate;
  logic [ACC_W-1:0]  frame_inc;
  logic              frame_pop;
  logic [ACC_W-1:0]  acc_sum;
  logic [RATE_W-1:0] head_rate;
  mode_t             mode_e;

  always_comb begin
    mode_e    = mode_t'(mode);
    head_rate = (fifo_head > RATE_MAX) ? RATE_W'(RATE_MAX) : fifo_head[RATE_W-1:0];

    tick_nxt   = tick_r;
    clk1_nxt   = clk1_r;
    ovf_nxt    = ovf_r;
    frame_nxt  = frame_r;
    acc_nxt    = acc_r;
    period_nxt = period_r;
    rate_nxt   = rate_r;

    fifo_ctrl       = '0;
    fifo_ctrl.data  = step_count;
    result          = '0;

    tick_inc  = tick_r + TICK_W'(1);
    wrap      = tick_inc > GATE_TOP;
    gate_on   = enable && !preset_held;
    half_gate = 1'b0;
    frame_inc = frame_r + ACC_W'(1);
    frame_pop = (frame_inc == {1'b0, period_r}) || (frame_inc == {period_r, 1'b0});
    acc_sum   = '0;

    case (mode_e)
      MODE_PUSH: begin
        fifo_ctrl.push = 1'b1;
      end
      MODE_PRESET: begin
        tick_nxt        = '0;
        frame_nxt       = '0;
        acc_nxt         = '0;
        rate_nxt        = '0;
        ovf_nxt         = 1'b0;
        fifo_ctrl.clear = 1'b1;
      end
      MODE_LOAD: begin
        fifo_ctrl.pop = 1'b1;
        period_nxt    = period_n;
        rate_nxt      = head_rate;
        acc_nxt       = ACC_W'(head_rate);
      end
      MODE_TICK: begin
        if (gate_on) begin
          tick_nxt  = wrap ? '0 : tick_inc;
          half_gate = tick_nxt <= GATE_HALF;
          if (tick_nxt == GATE_HALF) begin
            clk1_nxt = 1'b1;
          end else if (tick_nxt == GATE_TOP) begin
            clk1_nxt = 1'b0;
          end
          // The pulse uses the overflow of the previous tick.
          result.pulse = ovf_r && !half_gate;
          result.wrap  = wrap;
        end else begin
          clk1_nxt = 1'b0;
        end

        result.flag = frame_inc <= {1'b0, period_r};
        if (frame_pop) begin
          fifo_ctrl.pop = 1'b1;
          period_nxt    = period_n;
          rate_nxt      = head_rate;
        end
        // The wrap test uses the freshly latched period.
        frame_nxt = (frame_inc >= {period_nxt, 1'b0}) ? '0 : frame_inc;

        acc_sum = acc_r + ACC_W'(rate_nxt);
        if (acc_sum >= {1'b0, period_nxt}) begin
          acc_nxt = acc_sum - {1'b0, period_nxt};
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum;
          ovf_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    result.clk1 = clk1_nxt;

    if (!fire) begin
      fifo_ctrl.push  = 1'b0;
      fifo_ctrl.pop   = 1'b0;
      fifo_ctrl.clear = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      clk1_r   <= 1'b0;
      ovf_r    <= 1'b0;
      frame_r  <= '0;
      acc_r    <= '0;
      period_r <= '0;
      rate_r   <= '0;
    end else if (fire) begin
      tick_r   <= tick_nxt;
      clk1_r   <= clk1_nxt;
      ovf_r    <= ovf_nxt;
      frame_r  <= frame_nxt;
      acc_r    <= acc_nxt;
      period_r <= period_nxt;
      rate_r   <= rate_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dda_step_pulse_generator_core.sv =====
// Top level of the DDA step-pulse generator: handshake registers and configuration.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one request per clock while the result side does not stall
// and returns exactly one result per request, presented on the result port
// from the result register: the request is captured in an input register,
// then, once the result slot is free, the gate counter, the frame counter, the
// command FIFO and the DDA accumulator are evaluated in one pass and the result
// register is loaded. A new request can follow in every cycle, so the
// sustained rate is one request per cycle, held back only when the result side
// stalls. Mode 0 is a tick, mode 1 pushes a step
// count into the ten-entry command FIFO (a push into a full FIFO replaces the
// last entry), mode 2 is a preset pulse that clears the counters, the
// accumulator, the rate and the FIFO, and mode 3 loads the first command.
// The period register is written through the cfg_ port and is copied into the
// active period at every command pop; write it only while no request is in
// flight. cfg_ready is always high.
module dda_step_pulse_generator_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_mode,
  input  wire logic                        in_enable,
  input  wire logic                        in_preset_held,
  input  wire logic [dspg_pkg::STEP_W-1:0] in_step_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_pulse_out,
  output logic                             out_clk1_out,
  output logic                             out_flag_out,
  output logic                             out_cycle_wrap,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dspg_pkg::STEP_W-1:0] cfg_period_n
);
  import dspg_pkg::*;

  // Input register.
  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic              s1_enable_r;
  logic              s1_preset_r;
  logic [STEP_W-1:0] s1_steps_r;

  // Result register.
  logic    out_valid_r;
  result_t out_r;

  logic [STEP_W-1:0] period_n_r;

  logic       out_free;
  logic       fire;
  fifo_ctrl_t fifo_ctrl;
  logic [STEP_W-1:0] fifo_head;
  result_t    result_nxt;

  // The result slot can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      period_n_r  <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= fire;
      end
      if (cfg_valid && cfg_ready) begin
        period_n_r <= cfg_period_n;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r   <= in_mode;
      s1_enable_r <= in_enable;
      s1_preset_r <= in_preset_held;
      s1_steps_r  <= in_step_count;
    end
    if (fire) begin
      out_r <= result_nxt;
    end
  end

  dspg_core_logic u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .mode        (s1_mode_r),
    .enable      (s1_enable_r),
    .preset_held (s1_preset_r),
    .step_count  (s1_steps_r),
    .period_n    (period_n_r),
    .fifo_head   (fifo_head),
    .fifo_ctrl   (fifo_ctrl),
    .result      (result_nxt)
  );

  dspg_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fifo_ctrl),
    .head  (fifo_head)
  );

  assign out_valid      = out_valid_r;
  assign out_pulse_out  = out_r.pulse;
  assign out_clk1_out   = out_r.clk1;
  assign out_flag_out   = out_r.flag;
  assign out_cycle_wrap = out_r.wrap;

endmodule
`default_nettype wire

// ===== bench/dspg_pulse_checker.sv =====
// Checker for the DDA step-pulse generator: watches all channels, predicts and compares results.
`timescale 1ns / 1ps
module dspg_pulse_checker
  import dspg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic              in_enable,
  input  logic              in_preset_held,
  input  logic [STEP_W-1:0] in_step_count,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_pulse_out,
  input  logic              out_clk1_out,
  input  logic              out_flag_out,
  input  logic              out_cycle_wrap,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_period_n,
  output int                fail_count,
  output int                pending_results
);

  // Private copy of the generator state.
  logic [STEP_W-1:0] period_reg;
  int                gate_count;
  logic              gate_half;
  logic              clk1_q;
  logic              ovf_q;
  logic [ACC_W-1:0]  frame_q;
  logic [ACC_W-1:0]  acc_q;
  logic [STEP_W-1:0] cur_period;
  logic [RATE_W-1:0] cur_rate;
  logic [STEP_W-1:0] cmd_q [FIFO_DEPTH];
  int                cmd_fill;

  result_t expected_pulses [$];
  int      fails = 0;

  task automatic clear_fifo_and_counters();
    gate_count = 0;
    frame_q    = '0;
    acc_q      = '0;
    cur_rate   = '0;
    gate_half  = 1'b0;
    ovf_q      = 1'b0;
    for (int i = 0; i < FIFO_DEPTH; i++) cmd_q[i] = '0;
    cmd_fill = 0;
  endtask

  task automatic pop_next_command();
    cur_period = period_reg;
    cur_rate   = (cmd_q[0] > RATE_MAX) ? RATE_W'(RATE_MAX) : RATE_W'(cmd_q[0]);
    for (int i = 0; i + 1 < FIFO_DEPTH; i++) cmd_q[i] = cmd_q[i+1];
    cmd_q[FIFO_DEPTH-1] = '0;
    if (cmd_fill > 0) cmd_fill--;
  endtask

  task automatic advance_generator(input mode_t m, input logic en, input logic pre,
                                   input logic [STEP_W-1:0] steps, output result_t r);
    logic [ACC_W-1:0] twice;
    r = '0;
    case (m)
      MODE_PUSH: begin
        if (cmd_fill < FIFO_DEPTH) cmd_fill++;
        cmd_q[cmd_fill-1] = steps;
      end
      MODE_PRESET: begin
        clear_fifo_and_counters();
      end
      MODE_LOAD: begin
        pop_next_command();
        acc_q = ACC_W'(cur_rate);
      end
      default: begin
        if (en && !pre) begin
          gate_count++;
          if (gate_count > int'(GATE_TOP)) begin
            gate_count = 0;
            r.wrap     = 1'b1;
          end
          gate_half = (gate_count <= int'(GATE_HALF));
          if (gate_count == int'(GATE_HALF)) clk1_q = 1'b1;
          else if (gate_count == int'(GATE_TOP)) clk1_q = 1'b0;
          // The pulse uses the overflow of the previous tick.
          r.pulse = ovf_q & ~gate_half;
        end else begin
          clk1_q = 1'b0;
        end

        frame_q = frame_q + 1'b1;
        r.flag  = (frame_q <= ACC_W'(cur_period));
        twice   = {cur_period, 1'b0};
        if (frame_q == ACC_W'(cur_period) || frame_q == twice) pop_next_command();
        // The wrap test uses the period latched by a pop on this tick.
        if (frame_q >= {cur_period, 1'b0}) frame_q = '0;

        acc_q = acc_q + ACC_W'(cur_rate);
        if (acc_q >= ACC_W'(cur_period)) begin
          acc_q = acc_q - ACC_W'(cur_period);
          ovf_q = 1'b1;
        end else begin
          ovf_q = 1'b0;
        end
      end
    endcase
    r.clk1 = clk1_q;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      period_reg = '0;
      clk1_q     = 1'b0;
      cur_period = '0;
      clear_fifo_and_counters();
      expected_pulses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_pulse_out, out_clk1_out, out_flag_out, out_cycle_wrap};
        if (expected_pulses.size() == 0) begin
          $display("%0t: result with none expected, expected nothing actual %b",
                   $time, seen);
          fails++;
        end else begin
          want = expected_pulses.pop_front();
          check_field("pulse_out", want.pulse, seen.pulse);
          check_field("clk1_out", want.clk1, seen.clk1);
          check_field("flag_out", want.flag, seen.flag);
          check_field("cycle_wrap", want.wrap, seen.wrap);
        end
      end
      if (in_valid && !in_stall) begin
        advance_generator(mode_t'(in_mode), in_enable, in_preset_held, in_step_count, want);
        expected_pulses.push_back(want);
      end
      if (cfg_valid && cfg_ready) period_reg = cfg_period_n;
    end
    fail_count      <= fails;
    pending_results <= expected_pulses.size();
  end

endmodule

// ===== bench/dda_step_pulse_generator_core_tb.sv =====
// Testbench top for the DDA step-pulse generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module dda_step_pulse_generator_core_tb;
  import dspg_pkg::*;

  // Number of random requests after the directed part.
  localparam int RANDOM_REQUESTS = 1700;
  // Requests per configuration phase.
  localparam int PHASE_REQUESTS  = 200;
  // Idle and stall chance, in percent.
  localparam int IDLE_PCT        = 15;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode        = MODE_TICK;
  logic              in_enable      = 1'b0;
  logic              in_preset_held = 1'b0;
  logic [STEP_W-1:0] in_step_count  = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_pulse_out;
  logic              out_clk1_out;
  logic              out_flag_out;
  logic              out_cycle_wrap;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [STEP_W-1:0] cfg_period_n   = '0;

  int fail_count;
  int pending_results;
  int sent_count = 0;
  // While set, neither side idles: a long back-to-back stretch.
  bit quiet = 1'b0;

  dda_step_pulse_generator_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_enable     (in_enable),
    .in_preset_held(in_preset_held),
    .in_step_count (in_step_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pulse_out (out_pulse_out),
    .out_clk1_out  (out_clk1_out),
    .out_flag_out  (out_flag_out),
    .out_cycle_wrap(out_cycle_wrap),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_period_n  (cfg_period_n)
  );

  dspg_pulse_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_enable      (in_enable),
    .in_preset_held (in_preset_held),
    .in_step_count  (in_step_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pulse_out  (out_pulse_out),
    .out_clk1_out   (out_clk1_out),
    .out_flag_out   (out_flag_out),
    .out_cycle_wrap (out_cycle_wrap),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_period_n   (cfg_period_n),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls at random except during quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Offers one request, possibly after some idle cycles, and holds it until
  // the block takes it. The payload never changes while the request is stalled.
  task automatic send_request(input mode_t m, input logic en, input logic pre,
                              input logic [STEP_W-1:0] sc);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_enable      <= en;
    in_preset_held <= pre;
    in_step_count  <= sc;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Stops sending and waits until every request has returned its result. The
  // checker's count is registered, so the task waits on the clock before its
  // first look, and afterwards waits on to cover the two-stage pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // The period register is only written with the block idle.
  task automatic write_period(input logic [STEP_W-1:0] value);
    drain_results();
    cfg_valid    <= 1'b1;
    cfg_period_n <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Step counts are mostly near the rate clamp so that both clamped and
  // unclamped rates are common, with full-range values mixed in.
  function automatic logic [STEP_W-1:0] pick_steps();
    if ($urandom_range(0, 99) < 60) return STEP_W'($urandom_range(0, 15));
    return STEP_W'($urandom);
  endfunction

  // A well-formed command sequence: optional preset, a burst of pushes that
  // sometimes overfills the FIFO, a load, then a run of ticks. Some runs are
  // heavily gated so the gated-off path sees long stretches too.
  task automatic run_command_sequence();
    int pushes;
    int ticks;
    int off_pct;
    if ($urandom_range(0, 1))
      send_request(MODE_PRESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pick_steps());
    pushes = $urandom_range(0, 12);
    repeat (pushes) send_request(MODE_PUSH, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), pick_steps());
    send_request(MODE_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 pick_steps());
    off_pct = ($urandom_range(0, 3) == 0) ? 40 : 4;
    ticks   = $urandom_range(10, 120);
    repeat (ticks) begin
      send_request(MODE_TICK, $urandom_range(0, 99) >= off_pct,
                   $urandom_range(0, 99) < off_pct / 2, STEP_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int phase;
    int phase_start;
    bit paused;
    logic [STEP_W-1:0] next_period;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the period at its reset value of zero the
    // accumulator overflows on every tick, and a load from the empty FIFO
    // gives a rate of zero.
    send_request(MODE_TICK, 1'b1, 1'b0, 16'h0000);
    send_request(MODE_LOAD, 1'b0, 1'b0, 16'hFFFF);
    // Eleven pushes: the last one lands on a full FIFO and replaces its tail.
    send_request(MODE_PUSH, 1'b0, 1'b0, 16'h0000);
    send_request(MODE_PUSH, 1'b1, 1'b1, 16'hFFFF);
    send_request(MODE_PUSH, 1'b0, 1'b0, 16'd10);
    send_request(MODE_PUSH, 1'b0, 1'b0, 16'd11);
    repeat (7) send_request(MODE_PUSH, 1'b1, 1'b0, pick_steps());
    write_period(16'd3);
    // A head of zero, then a head far above the clamp.
    send_request(MODE_LOAD, 1'b1, 1'b0, 16'h0000);
    send_request(MODE_LOAD, 1'b1, 1'b0, 16'h0000);
    // Ticks with the block gated off by enable, by preset, and by both.
    send_request(MODE_TICK, 1'b0, 1'b0, 16'h0000);
    send_request(MODE_TICK, 1'b1, 1'b1, 16'h0000);
    send_request(MODE_TICK, 1'b0, 1'b1, 16'hFFFF);
    repeat (5) send_request(MODE_TICK, 1'b1, 1'b0, 16'h0000);
    send_request(MODE_PRESET, 1'b1, 1'b0, 16'hFFFF);
    send_request(MODE_TICK, 1'b1, 1'b0, 16'h0000);

    // Random part, in phases with different periods, the extremes among them.
    sent_count = 0;
    phase      = 0;
    paused     = 1'b0;
    while (sent_count < RANDOM_REQUESTS) begin
      case (phase % 8)
        0:       next_period = 16'd1;
        1:       next_period = 16'hFFFF;
        2:       next_period = 16'd0;
        3:       next_period = STEP_W'($urandom_range(2, 12));
        4:       next_period = STEP_W'($urandom_range(13, 80));
        5:       next_period = STEP_W'($urandom);
        6:       next_period = 16'd2;
        default: next_period = STEP_W'($urandom_range(3, 30));
      endcase
      write_period(next_period);
      quiet       = (phase == 2);
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_REQUESTS && sent_count < RANDOM_REQUESTS) begin
        if ($urandom_range(0, 4) == 0) begin
          // Noise: requests of any mode with any content.
          repeat ($urandom_range(1, 5))
            send_request(mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), pick_steps());
        end else begin
          run_command_sequence();
        end
        // Once in the run, hold the sender back until every result is in.
        if (phase == 4 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
      end
      phase++;
    end

    quiet = 1'b0;
    drain_results();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Safety net for a block that stops answering.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
